[hw/rtl/imr_pkg.sv]
`timescale 1ns / 1ps
package imr_pkg;

  localparam int IMR_MAX_WIDTH  = 256;
  localparam int IMR_MAX_HEIGHT = 256;
  localparam int IMR_DIM_W      = 9;
  localparam int IMR_PIX_W      = 24;
  localparam int IMR_APB_DW     = 32;
  localparam int IMR_APB_AW     = 3;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic [1:0] STS_OK          = 2'd0;
  localparam logic [1:0] STS_LOAD_FULL   = 2'd1;
  localparam logic [1:0] STS_EARLY_DRAIN = 2'd2;

  typedef struct packed {
    logic do_load;
    logic reject_load;
    logic early_drain;
    logic pad_drain;
    logic pix_read;
    logic pix_emit;
  } imr_cmd_t;

  typedef struct packed {
    logic full;
    logic pad_busy;
  } imr_sts_t;

endpackage

[hw/rtl/image_rotate_90_clockwise_unit.sv]
`timescale 1ns / 1ps
// Channel  | Dir | Handshake            | Payload
// in_      | in  | in_tvalid/in_tready  | tdata: blue, green, red; tuser: req_type
// out_     | out | out_tvalid/out_tready| tdata: out_byte; tuser: is_padding, status;
//          |     |                      | tlast: last_byte
// cfg      | in  | APB, pready tied 1   | reg 0 image_width @0x0, reg 1 image_height @0x4
//
// Loads, ignored loads, early drains and padding bytes are answered straight from the accepted beat.
// A pixel byte first takes a registered pixel memory read, then is emitted from the read state.
// Synchronous active-low reset; no clearing pass, pixel memory is not reset.
// in_tready drops while a byte read is in flight or the output register is stalled.
module image_rotate_90_clockwise_unit #(
  parameter int MAX_WIDTH  = imr_pkg::IMR_MAX_WIDTH,
  parameter int MAX_HEIGHT = imr_pkg::IMR_MAX_HEIGHT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [23:0]                    in_tdata,   // [7:0] blue, [15:8] green, [23:16] red
  input  logic                           in_tuser,   // [0] req_type
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [7:0]                     out_tdata,  // [7:0] out_byte
  output logic [2:0]                     out_tuser,  // [0] is_padding, [2:1] status
  output logic                           out_tlast,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [imr_pkg::IMR_APB_AW-1:0] paddr,
  input  logic [imr_pkg::IMR_APB_DW-1:0] pwdata,
  output logic [imr_pkg::IMR_APB_DW-1:0] prdata,
  output logic                           pready
);
  import imr_pkg::*;

  logic [IMR_DIM_W-1:0] width_r, height_r;
  logic                 cfg_wr;
  logic                 reg_sel;
  imr_cmd_t             cmd;
  imr_sts_t             sts;
  logic                 is_padding;
  logic [1:0]           status;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= IMR_DIM_W'(1);
      height_r <= IMR_DIM_W'(1);
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_WIDTH:  width_r  <= pwdata[IMR_DIM_W-1:0];
        REG_HEIGHT: height_r <= pwdata[IMR_DIM_W-1:0];
        default:    width_r  <= width_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_WIDTH:  prdata = IMR_APB_DW'(width_r);
      REG_HEIGHT: prdata = IMR_APB_DW'(height_r);
      default:    prdata = '0;
    endcase
  end

  imr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .req_type   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  imr_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_restart (cfg_wr),
    .width_raw   (width_r),
    .height_raw  (height_r),
    .pixel       (in_tdata),
    .cmd         (cmd),
    .sts         (sts),
    .out_byte    (out_tdata),
    .is_padding  (is_padding),
    .last_byte   (out_tlast),
    .status      (status)
  );

  assign out_tuser = {status, is_padding};

endmodule

[hw/rtl/imr_ctrl.sv]
`timescale 1ns / 1ps
module imr_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic            req_type,
  output logic            out_tvalid,
  input  logic            out_tready,
  input  imr_pkg::imr_sts_t sts,
  output imr_pkg::imr_cmd_t cmd
);
  import imr_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic acc;
  logic emit;

  assign in_tready  = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign acc        = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          if (req_type == REQ_LOAD) begin
            cmd.reject_load = sts.full;
            cmd.do_load     = !sts.full;
          end else if (!sts.full) begin
            cmd.early_drain = 1'b1;
          end else if (sts.pad_busy) begin
            cmd.pad_drain = 1'b1;
          end else begin
            cmd.pix_read = 1'b1;
            state_nxt    = ST_READ;
          end
        end
      end
      ST_READ: begin
        cmd.pix_emit = 1'b1;
        state_nxt    = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign emit = cmd.do_load | cmd.reject_load | cmd.early_drain | cmd.pad_drain | cmd.pix_emit;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[hw/rtl/imr_dp.sv]
`timescale 1ns / 1ps
module imr_dp #(
  parameter int MAX_WIDTH  = imr_pkg::IMR_MAX_WIDTH,
  parameter int MAX_HEIGHT = imr_pkg::IMR_MAX_HEIGHT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_restart,
  input  logic [imr_pkg::IMR_DIM_W-1:0] width_raw,
  input  logic [imr_pkg::IMR_DIM_W-1:0] height_raw,
  input  logic [imr_pkg::IMR_PIX_W-1:0] pixel,
  input  imr_pkg::imr_cmd_t             cmd,
  output imr_pkg::imr_sts_t             sts,
  output logic [7:0]                    out_byte,
  output logic                          is_padding,
  output logic                          last_byte,
  output logic [1:0]                    status
);
  import imr_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LCW   = $clog2(DEPTH + 1);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int CWW   = (WW > IMR_DIM_W) ? WW : IMR_DIM_W;
  localparam int CWH   = (HW > IMR_DIM_W) ? HW : IMR_DIM_W;

  logic [IMR_PIX_W-1:0] mem [DEPTH];
  logic [IMR_PIX_W-1:0] rd_data_r;

  logic [WW-1:0]  w, wm1;
  logic [HW-1:0]  h, hm1;
  logic [1:0]     row_pad;
  logic [LCW-1:0] total_r;
  logic [LCW-1:0] loaded_r, loaded_nxt;
  logic [WW-1:0]  row_r, row_nxt;
  logic [HW-1:0]  col_r, col_nxt;
  logic [1:0]     phase_r, phase_nxt;
  logic [1:0]     pad_r, pad_nxt;
  logic [AW-1:0]  row_start_r, row_start_nxt;
  logic [AW-1:0]  addr_r, addr_nxt;
  logic           end_row, last;
  logic [7:0]     byte_val;
  logic           emit;

  logic [7:0] byte_r;
  logic       pad_flag_r;
  logic       last_r;
  logic [1:0] status_r;

  always_comb begin
    if (width_raw == '0) begin
      w = WW'(1);
    end else if (CWW'(width_raw) > CWW'(MAX_WIDTH)) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = WW'(width_raw);
    end
    if (height_raw == '0) begin
      h = HW'(1);
    end else if (CWH'(height_raw) > CWH'(MAX_HEIGHT)) begin
      h = HW'(MAX_HEIGHT);
    end else begin
      h = HW'(height_raw);
    end
  end

  assign wm1 = w - WW'(1);
  assign hm1 = h - HW'(1);
  // 3*h bytes per row; pad to a multiple of four works out to h mod 4
  assign row_pad = 2'(h);

  assign sts.full     = (loaded_r >= total_r);
  assign sts.pad_busy = (pad_r != 2'd0);

  always_comb begin
    unique case (phase_r)
      2'd0:    byte_val = rd_data_r[7:0];
      2'd1:    byte_val = rd_data_r[15:8];
      default: byte_val = rd_data_r[23:16];
    endcase
  end

  always_comb begin
    loaded_nxt    = loaded_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    phase_nxt     = phase_r;
    pad_nxt       = pad_r;
    row_start_nxt = row_start_r;
    addr_nxt      = addr_r;
    end_row       = 1'b0;
    last          = 1'b0;

    if (cmd.do_load) begin
      loaded_nxt    = loaded_r + LCW'(1);
      row_start_nxt = AW'(wm1);
      addr_nxt      = AW'(wm1);
    end

    if (cmd.pad_drain) begin
      pad_nxt = pad_r - 2'd1;
      end_row = (pad_r == 2'd1);
    end

    if (cmd.pix_emit) begin
      if (phase_r == 2'd2) begin
        phase_nxt = 2'd0;
        if (col_r == hm1) begin
          col_nxt = '0;
          if (row_pad != 2'd0) begin
            pad_nxt = row_pad;
          end else begin
            end_row = 1'b1;
          end
        end else begin
          col_nxt  = col_r + HW'(1);
          addr_nxt = AW'(LCW'(addr_r) + LCW'(w));
        end
      end else begin
        phase_nxt = phase_r + 2'd1;
      end
    end

    if (end_row) begin
      if (row_r == wm1) begin
        last = 1'b1;
      end else begin
        row_nxt       = row_r + WW'(1);
        row_start_nxt = row_start_r - AW'(1);
        addr_nxt      = row_start_r - AW'(1);
      end
    end

    if (last || cfg_restart) begin
      loaded_nxt = '0;
      row_nxt    = '0;
      col_nxt    = '0;
      phase_nxt  = 2'd0;
      pad_nxt    = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r <= '0;
      row_r    <= '0;
      col_r    <= '0;
      phase_r  <= 2'd0;
      pad_r    <= 2'd0;
      total_r  <= LCW'(1);
    end else begin
      loaded_r <= loaded_nxt;
      row_r    <= row_nxt;
      col_r    <= col_nxt;
      phase_r  <= phase_nxt;
      pad_r    <= pad_nxt;
      total_r  <= LCW'(LCW'(w) * LCW'(h));
    end
  end

  always_ff @(posedge clk) begin
    row_start_r <= row_start_nxt;
    addr_r      <= addr_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.do_load) begin
      mem[loaded_r[AW-1:0]] <= pixel;
    end
    if (cmd.pix_read) begin
      rd_data_r <= mem[addr_r];
    end
  end

  assign emit = cmd.do_load | cmd.reject_load | cmd.early_drain | cmd.pad_drain | cmd.pix_emit;

  always_ff @(posedge clk) begin
    if (emit) begin
      byte_r     <= cmd.pix_emit ? byte_val : 8'd0;
      pad_flag_r <= cmd.pad_drain;
      last_r     <= last;
      if (cmd.reject_load) begin
        status_r <= STS_LOAD_FULL;
      end else if (cmd.early_drain) begin
        status_r <= STS_EARLY_DRAIN;
      end else begin
        status_r <= STS_OK;
      end
    end
  end

  assign out_byte   = byte_r;
  assign is_padding = pad_flag_r;
  assign last_byte  = last_r;
  assign status     = status_r;

endmodule
